// ===== hw/rtl/flp_pkg.sv =====
// Package with widths, coefficients and output rounding for the 30-tap low-pass filter.
`default_nettype none
package flp_pkg;

    localparam int TAPS     = 30;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = COEF_W - 1;
    localparam int ACC_W    = SAMPLE_W + COEF_W + $clog2(TAPS);
    localparam int SHIFT_W  = ACC_W - FRAC_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam coef_t COEFS [TAPS] = '{
        -16'sd11,    16'sd58,    16'sd184,   16'sd343,   16'sd429,   16'sd305,
        -16'sd101,  -16'sd696,  -16'sd1182, -16'sd1149, -16'sd259,   16'sd1532,
         16'sd3869,  16'sd6077,  16'sd7419,  16'sd7419,  16'sd6077,  16'sd3869,
         16'sd1532, -16'sd259,  -16'sd1149, -16'sd1182, -16'sd696,  -16'sd101,
         16'sd305,   16'sd429,   16'sd343,   16'sd184,   16'sd58,   -16'sd11
    };

    localparam acc_t    ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // round half up to the sample grid, then clamp
    function automatic sample_t round_sat(input acc_t acc);
        acc_t                      biased;
        logic signed [SHIFT_W-1:0] shifted;
        sample_t                   res;
        biased  = acc + ROUND_HALF;
        shifted = biased[ACC_W-1:FRAC_W];
        if (shifted > SHIFT_W'(SAMPLE_MAX))
            res = SAMPLE_MAX;
        else if (shifted < SHIFT_W'(SAMPLE_MIN))
            res = SAMPLE_MIN;
        else
            res = shifted[SAMPLE_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/flp_in_if.sv =====
// Input channel interface carrying one sample word.
`default_nettype none
interface flp_in_if;
    logic                     valid;
    logic                     ready;
    flp_pkg::sample_t         sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/flp_out_if.sv =====
// Output channel interface carrying one filtered word.
`default_nettype none
interface flp_out_if;
    logic                     valid;
    logic                     ready;
    flp_pkg::sample_t         filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink   (input valid, input filtered_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/flp_cell.sv =====
// One tap cell of the transposed filter: multiply, add the neighbor's sum, register.
`default_nettype none
module flp_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire flp_pkg::sample_t sample,
    input  wire flp_pkg::coef_t   coef,
    input  wire flp_pkg::acc_t    sum_in,
    output flp_pkg::acc_t         sum_out
);
    import flp_pkg::*;

    logic signed [SAMPLE_W+COEF_W-1:0] prod;
    acc_t                              sum_reg;
    acc_t                              sum_next;

    always_comb
    begin
        prod     = sample * coef;
        sum_next = ACC_W'(prod) + sum_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (en)
            sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/flp_out.sv =====
// Output stage: holds the result valid flag and rounds and clamps the head cell's sum.
`default_nettype none
module flp_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire flp_pkg::acc_t acc,
    output logic               take,
    flp_out_if.source          dout
);
    import flp_pkg::*;

    logic valid_reg;
    logic valid_next;

    always_comb
    begin
        take       = !valid_reg || dout.ready;
        valid_next = load || (valid_reg && !dout.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign dout.valid        = valid_reg;
    assign dout.filtered_out = round_sat(acc);
endmodule
`default_nettype wire

// ===== hw/rtl/fir_lowpass_30tap_top.sv =====
// Top level of the 30-tap low-pass filter: a row of tap cells and an output stage.
//
//   channel   dir   word           fields
//   din       in    one sample     sample_in    (16 bits, signed Q1.15)
//   dout      out   one result     filtered_out (16 bits, signed Q1.15)
//
// One sample enters per cycle while din is ready; its result is valid the cycle after acceptance.
// Every cell advances its partial sum only when a sample is accepted.
// Reset clears all partial sums, so the filter starts from an all-zero history.
// A stalled result holds; din stays ready while dout is empty or being taken.
`default_nettype none
module fir_lowpass_30tap_top (
    input  wire logic clk,
    input  wire logic rst_n,
    flp_in_if.sink    din,
    flp_out_if.source dout
);
    import flp_pkg::*;

    acc_t sums [TAPS];
    logic take;
    logic accept;

    assign din.ready = take;
    assign accept    = din.valid && take;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_tap
        acc_t chain_in;
        if (i == TAPS - 1)
        begin : g_last
            assign chain_in = '0;
        end
        else
        begin : g_mid
            assign chain_in = sums[i+1];
        end

        flp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .sample  (din.sample_in),
            .coef    (COEFS[i]),
            .sum_in  (chain_in),
            .sum_out (sums[i])
        );
    end

    flp_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .acc   (sums[0]),
        .take  (take),
        .dout  (dout)
    );

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> dout.valid)
        else $error("accepted sample produced no result");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && !accept) |=> !dout.valid)
        else $error("result repeated after being taken");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(sums[0]))
        else $error("head sum moved without an accepted sample");
endmodule
`default_nettype wire

// ===== tb/fir_lowpass_30tap_top_tb.sv =====
// Testbench for the 30-tap low-pass filter: scripted and random samples checked against a predictor.
`default_nettype none
module fir_lowpass_30tap_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flp_pkg::*;

    localparam int RANDOM_WORDS = 525;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int SCRIPT_LEN   = 25;

    typedef enum int {
        BURST_UNIFORM,
        BURST_SMALL,
        BURST_EXTREME,
        BURST_HOLD,
        BURST_SIGNED
    } burst_e;

    typedef struct packed {
        sample_t word;
        logic    typed;
        sample_t result;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{16'sd0,     1'b1, 16'sd0},
        '{16'sd16384, 1'b1, -16'sd5},
        '{16'sd0,     1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MIN, 1'b0, 16'sd0},
        '{16'sd1,     1'b0, 16'sd0},
        '{-16'sd1,    1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b0, 16'sd0},
        '{SAMPLE_MAX, 1'b1, SAMPLE_MAX}
    };

    logic    clk;
    logic    rst_n;
    logic    chk_typed;
    sample_t typed_result;
    logic    steady;

    sample_t history [TAPS];
    sample_t filtered_q [$];
    sample_t oldest;
    sample_t predicted;
    int      in_words;
    int      out_words;
    int      rail_hits;
    int      errors;
    int      quiet_cycles;

    flp_in_if  din_if ();
    flp_out_if dout_if ();

    fir_lowpass_30tap_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic sample_t filter_step(input sample_t x);
        longint acc;
        longint rounded;
        int     n;
        for (n = TAPS - 1; n > 0; n--)
        begin
            history[n] = history[n-1];
        end
        history[0] = x;
        acc = 0;
        for (n = 0; n < TAPS; n++)
        begin
            acc += longint'(COEFS[n]) * longint'(history[n]);
        end
        rounded = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (rounded > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (rounded < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(rounded);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_word(input sample_t w, input logic typed, input sample_t res);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid     <= 1'b1;
        din_if.sample_in <= w;
        chk_typed        <= typed;
        typed_result     <= res;
        do
        begin
            @(posedge clk);
        end
        while (!din_if.ready);
    endtask

    task automatic drain_pause();
        din_if.valid <= 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("filtered_out with nothing expected: actual %0d",
                           dout_if.filtered_out);
                    errors++;
                end
                else
                begin
                    oldest = filtered_q.pop_front();
                    if (dout_if.filtered_out !== oldest)
                    begin
                        $error("filtered_out mismatch: expected %0d, actual %0d",
                               oldest, dout_if.filtered_out);
                        errors++;
                    end
                    out_words++;
                end
            end
            if (din_if.valid && din_if.ready)
            begin
                predicted = filter_step(din_if.sample_in);
                filtered_q.push_back(chk_typed ? typed_result : predicted);
                if (predicted == SAMPLE_MAX || predicted == SAMPLE_MIN)
                    rail_hits++;
                in_words++;
            end
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("fir_lowpass_30tap_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int run;
        int gap;
        dout_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (steady)
            begin
                dout_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 30);
                dout_if.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    dout_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        burst_e  kind;
        sample_t w;
        int      len;
        int      p;
        int      i;
        int      bursts;
        logic    neg;
        for (i = 0; i < TAPS; i++)
        begin
            history[i] = '0;
        end
        in_words     = 0;
        out_words    = 0;
        rail_hits    = 0;
        errors       = 0;
        quiet_cycles = 0;
        bursts       = 0;
        steady       = 1'b0;
        rst_n            <= 1'b0;
        din_if.valid     <= 1'b0;
        din_if.sample_in <= '0;
        chk_typed        <= 1'b0;
        typed_result     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < SCRIPT_LEN; i++)
        begin
            send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].result);
        end

        while (in_words < SCRIPT_LEN + RANDOM_WORDS)
        begin
            p = $urandom_range(0, 99);
            if (p < 40)
                kind = BURST_UNIFORM;
            else if (p < 55)
                kind = BURST_SMALL;
            else if (p < 70)
                kind = BURST_EXTREME;
            else if (p < 85)
                kind = BURST_HOLD;
            else
                kind = BURST_SIGNED;
            case (kind)
                BURST_HOLD:   len = $urandom_range(20, 40);
                BURST_SIGNED: len = $urandom_range(30, 60);
                default:      len = $urandom_range(8, 40);
            endcase
            neg    = 1'($urandom_range(0, 1));
            steady = ($urandom_range(0, 7) == 0);
            if (bursts == 3 || $urandom_range(0, 9) == 0)
                drain_pause();
            for (i = 0; i < len; i++)
            begin
                case (kind)
                    BURST_UNIFORM:
                        w = sample_t'($urandom_range(0, 16'hFFFF));
                    BURST_SMALL:
                        w = sample_t'(int'($urandom_range(0, 1023)) - 512);
                    BURST_EXTREME:
                    begin
                        case ($urandom_range(0, 4))
                            0:       w = SAMPLE_MAX;
                            1:       w = SAMPLE_MIN;
                            2:       w = 16'sd1;
                            3:       w = -16'sd1;
                            default: w = 16'sd0;
                        endcase
                    end
                    BURST_HOLD:
                        w = neg ? SAMPLE_MIN : SAMPLE_MAX;
                    default:
                        w = ((COEFS[i % TAPS] >= 0) ^ neg) ? SAMPLE_MAX : SAMPLE_MIN;
                endcase
                send_word(w, 1'b0, '0);
            end
            bursts++;
        end
        steady = 1'b0;

        din_if.valid <= 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Filtered %0d samples in %0d bursts after the scripted rows;", in_words, bursts);
        $display("checked %0d outputs, %0d of them clipped at a rail.", out_words, rail_hits);
        if (errors == 0)
            $display("fir_lowpass_30tap_top_tb OK");
        else
            $display("fir_lowpass_30tap_top_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
